// ===== rtl/core/rqr_pkg.sv =====
package rqr_pkg;

  // field and register widths
  localparam int SW      = 16;
  localparam int SW1     = SW + 1;
  localparam int STEP_W  = 13;
  localparam int OFF_W   = 16;
  localparam int BD_W    = 5;
  localparam int IDX_W   = 2;

  // divider geometry: numerator 2*t+s is below 2^19, divisor 2*s below 2^14
  localparam int NUM_W   = 19;
  localparam int DEN_W   = STEP_W + 1;
  localparam int N_CELLS = NUM_W;

  // reconstruct path widths
  localparam int PROD_W  = SW + STEP_W;
  localparam int R_W     = PROD_W + 2;

  // register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_STEP_SIZE    = 2'd0;
  localparam logic [IDX_W-1:0] REG_LEVEL_OFFSET = 2'd1;
  localparam logic [IDX_W-1:0] REG_BIT_DEPTH    = 2'd2;

  // modes
  localparam logic MODE_QUANT = 1'b0;
  localparam logic MODE_RECON = 1'b1;

  // payload handed from cell to cell, remainder is below the divisor
  typedef struct packed {
    logic              mode;
    logic              last;
    logic              neg;
    logic [NUM_W-1:0]  nq;
    logic [DEN_W-1:0]  rem;
    logic [DEN_W-1:0]  den;
    logic [PROD_W-1:0] prod;
    logic [SW-1:0]     pred;
  } cell_t;

  // clamp maximum 2^bd - 1, bit depth limited to the sample width
  function automatic logic [SW-1:0] clamp_max(input logic [BD_W-1:0] bd);
    logic [BD_W-1:0] b;
    logic [SW1-1:0]  one_hot;
    b       = (bd > BD_W'(SW)) ? BD_W'(SW) : bd;
    one_hot = SW1'(1) << b;
    return SW'(one_hot - SW1'(1));
  endfunction

endpackage

// ===== rtl/core/rqr_front.sv =====
module rqr_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  logic                      mode,
  input  logic [rqr_pkg::SW-1:0]    value_in,
  input  logic [rqr_pkg::SW-1:0]    prediction,
  input  logic                      last_sample,
  input  logic [rqr_pkg::STEP_W-1:0] step_size,
  input  logic [rqr_pkg::OFF_W-1:0] level_offset,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output rqr_pkg::cell_t            dn_data
);

  logic                       valid_r;
  rqr_pkg::cell_t             data_r;
  rqr_pkg::cell_t             data_nxt;
  logic [rqr_pkg::STEP_W-1:0] step_eff;
  logic signed [rqr_pkg::NUM_W-1:0] t_res;
  logic signed [rqr_pkg::NUM_W:0]   num;

  // a zero step behaves as one
  assign step_eff = (step_size == '0) ? rqr_pkg::STEP_W'(1) : step_size;

  // offset residual, numerator 2*t+s, divisor 2*s and reconstruct product
  always_comb begin
    t_res = signed'(rqr_pkg::NUM_W'(value_in)) - signed'(rqr_pkg::NUM_W'(prediction))
          + signed'(rqr_pkg::NUM_W'(level_offset));
    num   = signed'({t_res, 1'b0}) + signed'((rqr_pkg::NUM_W + 1)'(step_eff));
    data_nxt.mode = mode;
    data_nxt.last = last_sample;
    data_nxt.neg  = num[rqr_pkg::NUM_W];
    data_nxt.nq   = num[rqr_pkg::NUM_W-1:0];
    data_nxt.rem  = '0;
    data_nxt.den  = {step_eff, 1'b0};
    data_nxt.prod = rqr_pkg::PROD_W'(value_in) * rqr_pkg::PROD_W'(step_eff);
    data_nxt.pred = prediction;
  end

  assign up_ready = !valid_r || dn_ready;

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== rtl/core/rqr_div_cell.sv =====
module rqr_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  rqr_pkg::cell_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output rqr_pkg::cell_t dn_data
);

  logic                        valid_r;
  rqr_pkg::cell_t              data_r;
  rqr_pkg::cell_t              data_nxt;
  logic [rqr_pkg::DEN_W:0]     partial;
  logic                        qbit;

  // one restoring step: bring down the next numerator bit, try the divisor
  always_comb begin
    data_nxt = up_data;
    partial  = {up_data.rem, up_data.nq[rqr_pkg::NUM_W-1]};
    qbit     = (partial >= (rqr_pkg::DEN_W + 1)'(up_data.den));
    if (qbit) begin
      data_nxt.rem = rqr_pkg::DEN_W'(partial - (rqr_pkg::DEN_W + 1)'(up_data.den));
    end else begin
      data_nxt.rem = partial[rqr_pkg::DEN_W-1:0];
    end
    data_nxt.nq = {up_data.nq[rqr_pkg::NUM_W-2:0], qbit};
  end

  assign up_ready = !valid_r || dn_ready;

  // cell valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // cell payload
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== rtl/core/rqr_back.sv =====
module rqr_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  rqr_pkg::cell_t             up_data,
  input  logic [rqr_pkg::OFF_W-1:0]  level_offset,
  input  logic [rqr_pkg::BD_W-1:0]   bit_depth,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rqr_pkg::SW-1:0]     value_out,
  output logic                       saturated,
  output logic                       last_out
);

  logic                        valid_r;
  logic [rqr_pkg::SW-1:0]      value_r;
  logic [rqr_pkg::SW-1:0]      value_nxt;
  logic                        sat_r;
  logic                        sat_nxt;
  logic                        last_r;
  logic [rqr_pkg::SW-1:0]      maxv;
  logic signed [rqr_pkg::R_W-1:0] recon;

  assign maxv = rqr_pkg::clamp_max(bit_depth);

  // final value and clamp for both modes
  always_comb begin
    recon = signed'(rqr_pkg::R_W'(up_data.prod)) + signed'(rqr_pkg::R_W'(up_data.pred))
          - signed'(rqr_pkg::R_W'(level_offset));
    value_nxt = '0;
    sat_nxt   = 1'b0;
    if (up_data.mode == rqr_pkg::MODE_QUANT) begin
      if (up_data.neg) begin
        sat_nxt = 1'b1;
      end else if (up_data.nq > rqr_pkg::NUM_W'(maxv)) begin
        value_nxt = maxv;
        sat_nxt   = 1'b1;
      end else begin
        value_nxt = up_data.nq[rqr_pkg::SW-1:0];
      end
    end else begin
      if (recon < 0) begin
        sat_nxt = 1'b1;
      end else if (recon > signed'(rqr_pkg::R_W'(maxv))) begin
        value_nxt = maxv;
        sat_nxt   = 1'b1;
      end else begin
        value_nxt = recon[rqr_pkg::SW-1:0];
      end
    end
  end

  assign up_ready = !valid_r || out_ready;

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      value_r <= value_nxt;
      sat_r   <= sat_nxt;
      last_r  <= up_data.last;
    end
  end

  assign out_valid = valid_r;
  assign value_out = value_r;
  assign saturated = sat_r;
  assign last_out  = last_r;

endmodule

// ===== rtl/core/residual_quantize_reconstruct.sv =====
// Per-sample residual quantizer and reconstructor. Mode 0 returns
// round-half-up((value_in - prediction + level_offset) / step_size), mode 1
// returns prediction + value_in*step_size - level_offset, both clamped to
// 0..2^bit_depth-1 with saturated set on clamping. One transaction is taken
// every cycle unless the pipeline stalls; each result passes through one input
// stage, a row of 19 divider cells giving one quotient bit each, and the
// output register. Each stage stalls only when the stage after it is full,
// so the input keeps flowing into empty stages while a result waits. Change
// configuration only while the block is empty.
module residual_quantize_reconstruct (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_mode,
  input  logic [rqr_pkg::SW-1:0]     in_value_in,
  input  logic [rqr_pkg::SW-1:0]     in_prediction,
  input  logic                       in_last_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rqr_pkg::SW-1:0]     out_value_out,
  output logic                       out_saturated,
  output logic                       out_last_out,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rqr_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rqr_pkg::OFF_W-1:0]  cfg_wdata
);

  logic [rqr_pkg::STEP_W-1:0] step_r;
  logic [rqr_pkg::OFF_W-1:0]  offset_r;
  logic [rqr_pkg::BD_W-1:0]   depth_r;

  logic           c_valid [rqr_pkg::N_CELLS+1];
  logic           c_ready [rqr_pkg::N_CELLS+1];
  rqr_pkg::cell_t c_data  [rqr_pkg::N_CELLS+1];

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= rqr_pkg::STEP_W'(1);
      offset_r <= rqr_pkg::OFF_W'(512);
      depth_r  <= rqr_pkg::BD_W'(10);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rqr_pkg::REG_STEP_SIZE:    step_r   <= cfg_wdata[rqr_pkg::STEP_W-1:0];
        rqr_pkg::REG_LEVEL_OFFSET: offset_r <= cfg_wdata;
        rqr_pkg::REG_BIT_DEPTH:    depth_r  <= cfg_wdata[rqr_pkg::BD_W-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  rqr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (in_valid),
    .up_ready     (in_ready),
    .mode         (in_mode),
    .value_in     (in_value_in),
    .prediction   (in_prediction),
    .last_sample  (in_last_sample),
    .step_size    (step_r),
    .level_offset (offset_r),
    .dn_valid     (c_valid[0]),
    .dn_ready     (c_ready[0]),
    .dn_data      (c_data[0])
  );

  // divider row, most significant quotient bit first
  for (genvar i = 0; i < rqr_pkg::N_CELLS; i++) begin : g_cell
    rqr_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (c_valid[i]),
      .up_ready (c_ready[i]),
      .up_data  (c_data[i]),
      .dn_valid (c_valid[i+1]),
      .dn_ready (c_ready[i+1]),
      .dn_data  (c_data[i+1])
    );
  end

  // clamp and output register
  rqr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (c_valid[rqr_pkg::N_CELLS]),
    .up_ready     (c_ready[rqr_pkg::N_CELLS]),
    .up_data      (c_data[rqr_pkg::N_CELLS]),
    .level_offset (offset_r),
    .bit_depth    (depth_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .value_out    (out_value_out),
    .saturated    (out_saturated),
    .last_out     (out_last_out)
  );

  // a clamped result sits on one of the two limits
  a_sat_on_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_value_out == '0) || (out_value_out == rqr_pkg::clamp_max(depth_r)))
    else $error("saturated result not on a clamp limit");

  // no result ever exceeds the clamp maximum
  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_value_out <= rqr_pkg::clamp_max(depth_r))
    else $error("result above clamp maximum");

  // the input only stalls once the whole row is full behind a held result
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with room in the pipeline");

endmodule

// ===== tb/sv/rqr_result_checker.sv =====
// watches the sample, result and register channels of the residual stage,
// predicts each result and compares it with what the block returns
module rqr_result_checker
  import rqr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             in_mode,
  input  logic [SW-1:0]    in_value_in,
  input  logic [SW-1:0]    in_prediction,
  input  logic             in_last_sample,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [SW-1:0]    out_value_out,
  input  logic             out_saturated,
  input  logic             out_last_out,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [OFF_W-1:0] cfg_wdata,
  output int               mismatches,
  output int               outstanding
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [SW-1:0] value;
    logic          sat;
    logic          last;
  } sample_result_t;

  // shadow copy of the block's registers
  logic [STEP_W-1:0] step_q;
  logic [OFF_W-1:0]  offset_q;
  logic [BD_W-1:0]   depth_q;

  sample_result_t expected_q[$];
  sample_result_t got;
  sample_result_t want;
  int             n_bad;

  // exact integer model of one sample, clamp to 0..2^depth-1
  function automatic sample_result_t predict_sample(logic mode, logic [SW-1:0] v,
                                                    logic [SW-1:0] p, logic last);
    longint          s;
    longint          t;
    longint          num;
    longint          den;
    longint          r;
    longint          maxv;
    logic [BD_W-1:0] b;
    sample_result_t  res;
    s    = (step_q == '0) ? 64'sd1 : longint'(step_q);
    b    = (depth_q > BD_W'(SW)) ? BD_W'(SW) : depth_q;
    maxv = (longint'(1) << b) - 1;
    if (mode == MODE_QUANT) begin
      // round half up: floor((2t + s) / 2s), floor towards minus infinity
      t   = longint'(v) - longint'(p) + longint'(offset_q);
      num = 2 * t + s;
      den = 2 * s;
      r   = (num >= 0) ? num / den : -((-num + den - 1) / den);
    end else begin
      r = longint'(p) + longint'(v) * s - longint'(offset_q);
    end
    res.sat = 1'b0;
    if (r > maxv) begin
      r       = maxv;
      res.sat = 1'b1;
    end
    if (r < 0) begin
      r       = 0;
      res.sat = 1'b1;
    end
    res.value = r[SW-1:0];
    res.last  = last;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      step_q      <= STEP_W'(1);
      offset_q    <= OFF_W'(512);
      depth_q     <= BD_W'(10);
      expected_q.delete();
      n_bad       = 0;
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      // register writes, unused indexes are ignored
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STEP_SIZE:    step_q   <= cfg_wdata[STEP_W-1:0];
          REG_LEVEL_OFFSET: offset_q <= cfg_wdata[OFF_W-1:0];
          REG_BIT_DEPTH:    depth_q  <= cfg_wdata[BD_W-1:0];
          default: ;
        endcase
      end

      // accepted sample transaction, appended behind the older predictions
      if (in_valid && in_ready) begin
        expected_q.insert(expected_q.size(),
                          predict_sample(in_mode, in_value_in, in_prediction,
                                         in_last_sample));
      end

      // accepted result transaction against the oldest prediction
      if (out_valid && out_ready) begin
        got.value = out_value_out;
        got.sat   = out_saturated;
        got.last  = out_last_out;
        if (expected_q.size() == 0) begin
          n_bad++;
          if (n_bad <= REPORT_LIMIT)
            $display("[%0t] unexpected result: value %0d sat %0b last %0b",
                     $time, got.value, got.sat, got.last);
        end else begin
          want = expected_q.pop_front();
          if (got.value !== want.value || got.sat !== want.sat ||
              got.last !== want.last) begin
            n_bad++;
            if (n_bad <= REPORT_LIMIT)
              $display("[%0t] result mismatch: value exp %0d got %0d,",
                       $time, want.value, got.value,
                       " sat exp %0b got %0b, last exp %0b got %0b",
                       want.sat, got.sat, want.last, got.last);
          end
        end
      end

      mismatches  <= n_bad;
      outstanding <= expected_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_residual_quantize_reconstruct.sv =====
module tb_residual_quantize_reconstruct;
  import rqr_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 30;
  localparam int RESET_CYCLES    = 12;
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  // idling profiles
  localparam int IDLE_NONE     = 0;
  localparam int IDLE_SENDER   = 1;
  localparam int IDLE_RECEIVER = 2;
  localparam int IDLE_BOTH     = 3;

  logic             clk;
  logic             rst_n          = 1'b0;
  logic             in_valid       = 1'b0;
  logic             in_mode        = MODE_QUANT;
  logic [SW-1:0]    in_value_in    = '0;
  logic [SW-1:0]    in_prediction  = '0;
  logic             in_last_sample = 1'b0;
  logic             out_ready      = 1'b0;
  logic             cfg_valid      = 1'b0;
  logic [IDX_W-1:0] cfg_index      = REG_STEP_SIZE;
  logic [OFF_W-1:0] cfg_wdata      = '0;
  logic             in_ready;
  logic             out_valid;
  logic [SW-1:0]    out_value_out;
  logic             out_saturated;
  logic             out_last_out;
  logic             cfg_ready;

  int idle_pct     = 0;
  int stall_pct    = 0;
  int cur_step     = 1;
  int cur_off      = 512;
  int cur_bd       = 10;
  int quiet_cycles = 0;
  int mismatches;
  int outstanding;

  residual_quantize_reconstruct uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_value_in    (in_value_in),
    .in_prediction  (in_prediction),
    .in_last_sample (in_last_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value_out  (out_value_out),
    .out_saturated  (out_saturated),
    .out_last_out   (out_last_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  rqr_result_checker result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_value_in    (in_value_in),
    .in_prediction  (in_prediction),
    .in_last_sample (in_last_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value_out  (out_value_out),
    .out_saturated  (out_saturated),
    .out_last_out   (out_last_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[residual_quantize_reconstruct] ERROR");
        $finish;
      end
    end
  end

  // one sample transaction, called and returning at a rising edge
  task automatic send_item(logic mode, logic [SW-1:0] v, logic [SW-1:0] p, logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_value_in    <= v;
    in_prediction  <= p;
    in_last_sample <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // one register write, with cfg_valid lowered again before returning
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [OFF_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold samples back until every prediction has been matched
  task automatic drain_pipeline;
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(int step_w, int off_w, int bd_w);
    drain_pipeline();
    write_reg(REG_STEP_SIZE, OFF_W'(step_w));
    write_reg(REG_LEVEL_OFFSET, OFF_W'(off_w));
    write_reg(REG_BIT_DEPTH, OFF_W'(bd_w));
    cur_step = step_w & 32'h1FFF;
    cur_off  = off_w & 32'hFFFF;
    cur_bd   = bd_w & 32'h1F;
  endtask

  // random sample, mostly aimed at the unclamped range of the current settings
  task automatic send_random;
    logic   mode;
    logic   last;
    longint s;
    longint maxv;
    longint target;
    longint d;
    longint p;
    longint v;
    longint q;
    mode = 1'($urandom_range(0, 1));
    last = ($urandom_range(0, 7) == 0);
    s    = longint'((cur_step == 0) ? 1 : cur_step);
    maxv = (longint'(1) << ((cur_bd > SW) ? SW : cur_bd)) - 1;
    p    = longint'($urandom_range(0, 65535));
    v    = longint'($urandom_range(0, 65535));
    if ($urandom_range(0, 9) >= 3) begin
      target = longint'($urandom_range(0, int'(maxv) + 1));
      if (mode == MODE_QUANT) begin
        // residual landing near target*step, either side of the rounding point
        d = target * s - cur_off + longint'($urandom_range(0, 2 * int'(s) - 1)) - s;
        if (d >= 0 && d <= 65535) begin
          p = longint'($urandom_range(0, 65535 - int'(d)));
          v = p + d;
        end else if (d < 0 && d >= -65535) begin
          p = longint'($urandom_range(int'(-d), 65535));
          v = p + d;
        end
      end else begin
        q = (target + cur_off) / s - longint'($urandom_range(0, 3));
        if (q < 0) q = 0;
        d = target + cur_off - q * s;
        if (d >= 0 && d <= 65535 && q <= 65535) begin
          p = d;
          v = q;
        end
      end
    end
    send_item(mode, SW'(v), SW'(p), last);
  endtask

  task automatic run_phase(int idle_sel, int n);
    case (idle_sel)
      IDLE_SENDER: begin
        idle_pct  = 67;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        idle_pct  = 0;
        stall_pct = 67;
      end
      IDLE_BOTH: begin
        idle_pct  = 20;
        stall_pct = 20;
      end
      default: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
    endcase
    repeat (n) send_random();
  endtask

  // stimulus
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: field extremes in both modes
    send_item(MODE_QUANT, 16'd0, 16'd0, 1'b0);
    send_item(MODE_QUANT, 16'hFFFF, 16'd0, 1'b1);
    send_item(MODE_QUANT, 16'd0, 16'hFFFF, 1'b0);
    send_item(MODE_QUANT, 16'hFFFF, 16'hFFFF, 1'b0);
    send_item(MODE_QUANT, 16'd100, 16'd400, 1'b0);
    send_item(MODE_RECON, 16'd0, 16'd0, 1'b0);
    send_item(MODE_RECON, 16'hFFFF, 16'hFFFF, 1'b1);
    send_item(MODE_RECON, 16'd600, 16'd0, 1'b0);
    // quantized residual beyond the clamp maximum, not clamped on entry
    send_item(MODE_RECON, 16'd1100, 16'd0, 1'b0);
    run_phase(IDLE_NONE, 80);

    set_config(4096, 0, 16);
    run_phase(IDLE_SENDER, 100);

    // step above the nominal range, full offset
    set_config(16'hFFFF, 16'hFFFF, 16);
    send_item(MODE_RECON, 16'hFFFF, 16'hFFFF, 1'b0);
    send_item(MODE_QUANT, 16'hFFFF, 16'd0, 1'b1);
    run_phase(IDLE_RECEIVER, 98);

    // zero step and zero bit depth
    set_config(0, 0, 0);
    send_item(MODE_QUANT, 16'd5, 16'd0, 1'b0);
    send_item(MODE_QUANT, 16'd0, 16'd0, 1'b0);
    send_item(MODE_RECON, 16'd0, 16'd0, 1'b1);
    run_phase(IDLE_BOTH, 97);

    // bit depth above the sample width, write to an unused index, exact halves
    set_config(4, 2, 17);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_item(MODE_QUANT, 16'd100, 16'd100, 1'b0);
    send_item(MODE_QUANT, 16'd96, 16'd100, 1'b0);
    send_item(MODE_QUANT, 16'd95, 16'd100, 1'b0);
    send_item(MODE_QUANT, 16'd103, 16'd100, 1'b1);
    run_phase(IDLE_NONE, 96);

    // sender waits for the pipeline to empty half way
    set_config(1, 16'hFFFF, 1);
    run_phase(IDLE_SENDER, 50);
    drain_pipeline();
    run_phase(IDLE_SENDER, 50);

    set_config(7, 200, 31);
    run_phase(IDLE_RECEIVER, 100);

    set_config(100, 32768, 12);
    run_phase(IDLE_BOTH, 100);

    set_config($urandom_range(1, 4096), $urandom_range(0, 65535), $urandom_range(1, 16));
    run_phase(IDLE_NONE, 100);

    // let the last results out, then the verdict
    drain_pipeline();
    if (mismatches == 0 && outstanding == 0) begin
      $display("[residual_quantize_reconstruct] OK");
    end else begin
      $display("[residual_quantize_reconstruct] ERROR");
    end
    $finish;
  end

endmodule
